[rtl/skrf_pkg.sv]
// ----------------------------------------------------------------------------
// skrf_pkg
// shared types and constants for the scalar kalman rate filter
// ----------------------------------------------------------------------------
package skrf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int DATA_W        = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL_X,
        S_UPD_X,
        S_MUL_P,
        S_UPD_P,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic first;
        logic prep;
        logic div_step;
        logic mul_x;
        logic upd_x;
        logic mul_p;
        logic upd_p;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic primed;
    } t_status;

endpackage

[rtl/skrf_datapath.sv]
// ----------------------------------------------------------------------------
// skrf_datapath
// filter state, noise registers, serial gain divider and shared multiplier
// ----------------------------------------------------------------------------
module skrf_datapath #(
    parameter int FRAC_BITS = skrf_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [skrf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [skrf_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic signed [skrf_pkg::DATA_W-1:0] i_sample,
    input  logic                              i_restart,
    input  skrf_pkg::t_cmd                    i_cmd,
    output skrf_pkg::t_status                 o_status,
    output logic signed [skrf_pkg::DATA_W-1:0] o_estimate_out,
    output logic [FRAC_BITS:0]                o_gain_out
);

    localparam int GW = FRAC_BITS + 1;
    localparam int PW = 34 + GW + 1;
    localparam int CW = PW - FRAC_BITS;
    localparam int SW = CW + 1;
    localparam logic [31:0]          ONE32   = 32'(1) << FRAC_BITS;
    localparam logic [GW-1:0]        ONEG    = GW'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0] HALF    = PW'(1) << (FRAC_BITS - 1);
    localparam logic [31:0]          Q_RESET = 32'((15 * (64'd1 << FRAC_BITS) + 5000) / 10000);
    localparam logic [31:0]          R_RESET = 32'((5 * (64'd1 << FRAC_BITS) + 50) / 100);
    localparam logic signed [SW-1:0] X_MAX   = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] X_MIN   = -SW'(64'sd2147483648);

    logic [31:0]          r_q_noise;
    logic [31:0]          r_r_noise;
    logic signed [31:0]   r_est;
    logic [31:0]          r_cov;
    logic                 r_primed;
    logic signed [31:0]   r_z;
    logic [31:0]          r_p;
    logic [32:0]          r_den;
    logic [33:0]          r_rem;
    logic [GW-1:0]        r_gain;
    logic signed [32:0]   r_diff;
    logic signed [PW-1:0] r_prod;
    logic signed [31:0]   r_out_est;
    logic [GW-1:0]        r_out_gain;

    logic [32:0]          p_sum;
    logic [31:0]          p_sat;
    logic                 div_ge;
    logic [33:0]          div_t;
    logic signed [33:0]   mul_a;
    logic signed [GW:0]   mul_b;
    logic signed [PW-1:0] mul_y;
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] rnd_sh;
    logic signed [CW-1:0] corr;
    logic signed [SW-1:0] x_sum;
    logic signed [31:0]   x_sat;

    always_comb begin
        p_sum  = {1'b0, r_cov} + {1'b0, r_q_noise};
        p_sat  = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
        div_ge = (r_den != 33'd0) && (r_rem >= {1'b0, r_den});
        div_t  = div_ge ? (r_rem - {1'b0, r_den}) : r_rem;
        if (i_cmd.mul_p) begin
            mul_a = {2'b00, r_p};
            mul_b = {1'b0, ONEG - r_gain};
        end else begin
            mul_a = {r_diff[32], r_diff};
            mul_b = {1'b0, r_gain};
        end
        mul_y  = mul_a * mul_b;
        rnd    = r_prod + HALF;
        rnd_sh = rnd >>> FRAC_BITS;
        corr   = rnd_sh[CW-1:0];
        x_sum  = SW'(r_est) + SW'(corr);
        if (x_sum > X_MAX) begin
            x_sat = 32'sh7FFF_FFFF;
        end else if (x_sum < X_MIN) begin
            x_sat = 32'sh8000_0000;
        end else begin
            x_sat = x_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_noise <= Q_RESET;
            r_r_noise <= R_RESET;
            r_est     <= '0;
            r_cov     <= ONE32;
            r_primed  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    skrf_pkg::REG_PROCESS_NOISE:     r_q_noise <= i_cfg_data;
                    skrf_pkg::REG_MEASUREMENT_NOISE: r_r_noise <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load && i_restart) begin
                r_est    <= '0;
                r_cov    <= ONE32;
                r_primed <= 1'b0;
            end
            if (i_cmd.first) begin
                r_est    <= r_z;
                r_primed <= 1'b1;
            end
            if (i_cmd.upd_x) begin
                r_est <= x_sat;
            end
            if (i_cmd.upd_p) begin
                r_cov <= rnd[FRAC_BITS +: 32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z <= i_sample;
        end
        if (i_cmd.first) begin
            r_gain <= '0;
        end
        if (i_cmd.prep) begin
            r_p    <= p_sat;
            r_den  <= {1'b0, p_sat} + {1'b0, r_r_noise};
            r_rem  <= {2'b00, p_sat};
            r_gain <= '0;
            r_diff <= {r_z[31], r_z} - {r_est[31], r_est};
        end
        if (i_cmd.div_step) begin
            r_rem  <= {div_t[32:0], 1'b0};
            r_gain <= {r_gain[GW-2:0], div_ge};
        end
        if (i_cmd.mul_x || i_cmd.mul_p) begin
            r_prod <= mul_y;
        end
        if (i_cmd.emit) begin
            r_out_est  <= r_est;
            r_out_gain <= r_gain;
        end
    end

    assign o_status.primed = r_primed;
    assign o_estimate_out  = r_out_est;
    assign o_gain_out      = r_out_gain;

endmodule

[rtl/skrf_controller.sv]
// ----------------------------------------------------------------------------
// skrf_controller
// step sequencer, divider bit counter and output handshake
// ----------------------------------------------------------------------------
module skrf_controller #(
    parameter int FRAC_BITS = skrf_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  skrf_pkg::t_status i_status,
    output skrf_pkg::t_cmd    o_cmd
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    skrf_pkg::t_state r_state;
    skrf_pkg::t_state n_state;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skrf_pkg::S_IDLE:   if (i_in_valid) n_state = skrf_pkg::S_PREP;
            skrf_pkg::S_PREP: begin
                n_state = i_status.primed ? skrf_pkg::S_DIV : skrf_pkg::S_FINISH;
            end
            skrf_pkg::S_DIV: begin
                if (r_cnt == CW'(FRAC_BITS)) n_state = skrf_pkg::S_MUL_X;
            end
            skrf_pkg::S_MUL_X:  n_state = skrf_pkg::S_UPD_X;
            skrf_pkg::S_UPD_X:  n_state = skrf_pkg::S_MUL_P;
            skrf_pkg::S_MUL_P:  n_state = skrf_pkg::S_UPD_P;
            skrf_pkg::S_UPD_P:  n_state = skrf_pkg::S_FINISH;
            skrf_pkg::S_FINISH: if (out_free) n_state = skrf_pkg::S_IDLE;
            default:            n_state = skrf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            skrf_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            skrf_pkg::S_PREP: begin
                o_cmd.first = !i_status.primed;
                o_cmd.prep  = i_status.primed;
                n_cnt       = '0;
            end
            skrf_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
            end
            skrf_pkg::S_MUL_X: o_cmd.mul_x = 1'b1;
            skrf_pkg::S_UPD_X: o_cmd.upd_x = 1'b1;
            skrf_pkg::S_MUL_P: o_cmd.mul_p = 1'b1;
            skrf_pkg::S_UPD_P: o_cmd.upd_p = 1'b1;
            skrf_pkg::S_FINISH: begin
                o_cmd.emit = out_free;
                if (out_free) n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skrf_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/scalar_kalman_rate_filter.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_rate_filter
// one-dimensional kalman filter for gyro rate samples
// ----------------------------------------------------------------------------
// One request is handled at a time. The first sample after reset or restart
// skips the divider and the multiplier; every later sample passes through
// the restoring gain divider, which retires one quotient bit per cycle,
// followed by two passes through the one shared multiplier. A new request
// is accepted in the cycle after the result is loaded into the output
// register, while that result may still be waiting to be taken. Noise
// registers are written through the configuration channel, which is always
// ready; the user must write them only while no request is in flight, and
// the block itself does not enforce this. Indexes above 1 are ignored.
module scalar_kalman_rate_filter #(
    parameter int FRAC_BITS = skrf_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [skrf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [skrf_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [skrf_pkg::DATA_W-1:0] i_sample,
    input  logic                               i_restart,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [skrf_pkg::DATA_W-1:0] o_estimate_out,
    output logic [FRAC_BITS:0]                 o_gain_out
);

    skrf_pkg::t_cmd    cmd;
    skrf_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    skrf_controller #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    skrf_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_restart      (i_restart),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_estimate_out (o_estimate_out),
        .o_gain_out     (o_gain_out)
    );

endmodule

[rtl/skrf_checker.sv]
// ----------------------------------------------------------------------------
// skrf_checker
// port-level checks for the scalar kalman rate filter
// ----------------------------------------------------------------------------
module skrf_checker #(
    parameter int FRAC_BITS = skrf_pkg::FRAC_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [skrf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [skrf_pkg::DATA_W-1:0]        i_cfg_data,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic signed [skrf_pkg::DATA_W-1:0] i_sample,
    input logic                               i_restart,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [skrf_pkg::DATA_W-1:0] o_estimate_out,
    input logic [FRAC_BITS:0]                 o_gain_out
);

    localparam logic [FRAC_BITS:0] GAIN_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    // one request in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one in flight");

    // no two results from one request: a fresh result needs an accept in between
    a_result_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_in_stall && !i_in_valid) |=> !o_out_valid)
        else $error("result appeared without a request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_estimate_out)
                                          && $stable(o_gain_out)))
        else $error("stalled result changed");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_gain_out <= GAIN_ONE))
        else $error("gain above one");

endmodule

bind scalar_kalman_rate_filter skrf_checker #(.FRAC_BITS(FRAC_BITS)) u_skrf_checker (.*);

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the scalar kalman rate filter
// ----------------------------------------------------------------------------
// Drives rate samples through the stall handshake and writes the noise
// registers between phases. A local fixed-point model computes the expected
// estimate and gain for every accepted sample, and a monitor compares each
// result as it is taken. Directed tests cover first samples, rounding ties,
// a zero denominator and covariance saturation. Random phases with new noise
// settings follow, plus one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC      = skrf_pkg::FRAC_BITS_DEF;
    localparam int DATA_W    = skrf_pkg::DATA_W;
    localparam int CFG_IDX_W = skrf_pkg::CFG_IDX_W;
    localparam logic [63:0] UNITY = 64'd1 << FRAC;
    localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC - 1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef struct {
        logic signed [DATA_W-1:0] estimate;
        logic [FRAC:0]            gain;
    } t_rate_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [DATA_W-1:0]           i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [DATA_W-1:0]    i_sample;
    logic                        i_restart;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [DATA_W-1:0]    o_estimate_out;
    logic [FRAC:0]               o_gain_out;

    // filter model state and noise settings
    logic signed [DATA_W-1:0]    mdl_est;
    logic [DATA_W-1:0]           mdl_cov;
    logic                        mdl_primed;
    logic [DATA_W-1:0]           mdl_q;
    logic [DATA_W-1:0]           mdl_r;

    t_rate_result rate_expect_q[$];
    int  err_count;
    int  n_sent;
    int  n_checked;
    int  n_restarts;
    int  n_cfg_writes;
    int  hold_cycles;
    bit  gap_en;
    int  rate_trend;

    scalar_kalman_rate_filter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_estimate_out (o_estimate_out),
        .o_gain_out     (o_gain_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", rate_expect_q.size());
        $display("Verification failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    function automatic void filter_reset();
        mdl_q      = 32'd98;
        mdl_r      = 32'd3277;
        mdl_est    = '0;
        mdl_cov    = UNITY[DATA_W-1:0];
        mdl_primed = 1'b0;
    endfunction

    // one filter step: prime on the first sample, else predict, gain, correct, shrink covariance
    function automatic t_rate_result kalman_step(input logic signed [DATA_W-1:0] z,
                                                 input logic rst_flag);
        logic [32:0]   p_sum;
        logic [31:0]   p_cur;
        logic [33:0]   den;
        logic [63:0]   gain_full;
        logic [63:0]   p_next;
        longint        diff;
        longint        corr;
        longint        x_new;
        t_rate_result  res;
        gain_full = '0;
        if (rst_flag) begin
            mdl_est    = '0;
            mdl_cov    = UNITY[DATA_W-1:0];
            mdl_primed = 1'b0;
        end
        if (!mdl_primed) begin
            mdl_est    = z;
            mdl_primed = 1'b1;
        end else begin
            p_sum = {1'b0, mdl_cov} + {1'b0, mdl_q};
            p_cur = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
            den   = {2'b0, p_cur} + {2'b0, mdl_r};
            if (den == '0) begin
                gain_full = '0;
            end else begin
                gain_full = ({32'd0, p_cur} << FRAC) / {30'd0, den};
            end
            if (gain_full > UNITY) begin
                gain_full = UNITY;
            end
            diff  = longint'(z) - longint'(mdl_est);
            corr  = (diff * longint'(gain_full) + longint'(HALF_LSB)) >>> FRAC;
            x_new = longint'(mdl_est) + corr;
            if (x_new > 64'sd2147483647) begin
                x_new = 64'sd2147483647;
            end
            if (x_new < -64'sd2147483648) begin
                x_new = -64'sd2147483648;
            end
            mdl_est = x_new[31:0];
            p_next  = ((UNITY - gain_full) * {32'd0, p_cur} + HALF_LSB) >> FRAC;
            mdl_cov = (p_next > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p_next[31:0];
        end
        res.estimate = mdl_est;
        res.gain     = gain_full[FRAC:0];
        return res;
    endfunction

    task automatic send_sample(input logic signed [DATA_W-1:0] smp, input logic rst_flag);
        int gap;
        if (gap_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        i_restart  <= rst_flag;
        do @(posedge i_clk); while (o_in_stall);
        rate_expect_q.push_back(kalman_step(smp, rst_flag));
        n_sent++;
        if (rst_flag) begin
            n_restarts++;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (rate_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_noise_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [DATA_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == skrf_pkg::REG_PROCESS_NOISE) begin
            mdl_q = value;
        end else if (idx == skrf_pkg::REG_MEASUREMENT_NOISE) begin
            mdl_r = value;
        end
        n_cfg_writes++;
    endtask

    // result monitor and output stall generator
    initial begin : result_monitor
        int           stall_left;
        t_rate_result want;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (rate_expect_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result est=%0d gain=%0d",
                                            o_estimate_out, o_gain_out));
                end else begin
                    want = rate_expect_q.pop_front();
                    n_checked++;
                    if (o_estimate_out !== want.estimate) begin
                        flag_mismatch($sformatf("result %0d estimate %0d, want %0d",
                                                n_checked, o_estimate_out, want.estimate));
                    end
                    if (o_gain_out !== want.gain) begin
                        flag_mismatch($sformatf("result %0d gain %0d, want %0d",
                                                n_checked, o_gain_out, want.gain));
                    end
                end
            end
            if (hold_cycles > 0) begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end else if (stall_left == 0 && gap_en && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 8);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic test_first_samples();
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(-32'sd1, 1'b1);
        send_sample(32'sd0, 1'b0);
        wait_drained();
    endtask

    // p equal to r gives a gain of one half, so odd differences land on ties
    task automatic test_rounding_ties();
        write_noise_reg(skrf_pkg::REG_PROCESS_NOISE, 32'd0);
        write_noise_reg(skrf_pkg::REG_MEASUREMENT_NOISE, UNITY[31:0]);
        send_sample(32'sd0, 1'b1);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd0, 1'b1);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        wait_drained();
    endtask

    task automatic test_zero_denominator();
        write_noise_reg(skrf_pkg::REG_PROCESS_NOISE, 32'd0);
        write_noise_reg(skrf_pkg::REG_MEASUREMENT_NOISE, 32'd0);
        send_sample(32'sd5, 1'b1);
        send_sample(32'sd100, 1'b0);
        send_sample(-32'sd7, 1'b0);
        wait_drained();
    endtask

    task automatic test_covariance_saturation();
        write_noise_reg(skrf_pkg::REG_PROCESS_NOISE, 32'hFFFF_FFFF);
        write_noise_reg(skrf_pkg::REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
        send_sample(32'sd1000, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        write_noise_reg(skrf_pkg::REG_MEASUREMENT_NOISE, 32'd1);
        send_sample(-32'sd65536, 1'b0);
        write_noise_reg(skrf_pkg::REG_MEASUREMENT_NOISE, 32'd0);
        send_sample(32'sh8000_0000, 1'b0);
        // indexes past the last register are ignored
        write_noise_reg(REG_SPARE_2, 32'd12345);
        write_noise_reg(REG_SPARE_3, 32'hFFFF_FFFF);
        send_sample(32'sd77, 1'b0);
        send_sample(32'sd0, 1'b1);
        wait_drained();
    endtask

    function automatic logic signed [DATA_W-1:0] pick_sample();
        logic [1:0] corner;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                corner = 2'($urandom_range(0, 3));
                case (corner)
                    2'd0: return 32'sh7FFF_FFFF;
                    2'd1: return 32'sh8000_0000;
                    2'd2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: begin
                rate_trend += int'($urandom_range(0, 4000)) - 2000;
                return rate_trend + int'($urandom_range(0, 131072)) - 65536;
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 70000);
        endcase
    endfunction

    // output held off long enough that the filter backs up its input
    task automatic test_output_holdoff();
        gap_en      = 1'b0;
        hold_cycles = 200;
        @(posedge i_clk);
        write_noise_reg(skrf_pkg::REG_PROCESS_NOISE, 32'd98);
        write_noise_reg(skrf_pkg::REG_MEASUREMENT_NOISE, 32'd3277);
        send_sample(pick_sample(), 1'b1);
        repeat (9) send_sample(pick_sample(), 1'b0);
        wait_drained();
        gap_en = 1'b1;
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            gap_en = (ph != 2) && (ph != 5);
            if (ph == 0) begin
                write_noise_reg(skrf_pkg::REG_PROCESS_NOISE, 32'd98);
                write_noise_reg(skrf_pkg::REG_MEASUREMENT_NOISE, 32'd3277);
            end else begin
                write_noise_reg(skrf_pkg::REG_PROCESS_NOISE, pick_noise());
                write_noise_reg(skrf_pkg::REG_MEASUREMENT_NOISE, pick_noise());
            end
            if ($urandom_range(0, 2) == 0) begin
                write_noise_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
            end
            rate_trend = int'($urandom_range(0, 2**25)) - 2**24;
            for (int k = 0; k < 155; k++) begin
                send_sample(pick_sample(), (k == 0) || ($urandom_range(0, 39) == 0));
            end
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        i_restart   <= 1'b0;
        err_count    = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_restarts   = 0;
        n_cfg_writes = 0;
        hold_cycles  = 0;
        gap_en       = 1'b1;
        rate_trend   = 0;
        filter_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_samples();
        test_rounding_ties();
        test_zero_denominator();
        test_covariance_saturation();
        test_output_holdoff();
        test_random_phases();

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (rate_expect_q.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", rate_expect_q.size()));
        end
        $display("Covered first samples, rounding ties, zero denominator, covariance limits,");
        $display("a long output hold-off and random phases: %0d samples (%0d restarts),",
                 n_sent, n_restarts);
        $display("%0d checked, %0d register writes", n_checked, n_cfg_writes);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/skrf_pkg.sv
rtl/skrf_datapath.sv
rtl/skrf_controller.sv
rtl/scalar_kalman_rate_filter.sv
rtl/skrf_checker.sv
dv/tb.sv
